// ===== rtl/ooat_pkg.sv =====
package ooat_pkg;

    localparam int HASH_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int SIZE_W       = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
    localparam int DIV_CNT_W    = $clog2(HASH_W);

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1021);

    localparam int MIX_SHL   = 10;
    localparam int MIX_SHR   = 6;
    localparam int FIN_SHL_A = 3;
    localparam int FIN_SHR   = 11;
    localparam int FIN_SHL_B = 15;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_DIV,
        S_HOLD
    } t_back_state;

    function automatic logic [HASH_W-1:0] mix_byte(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] c;
        a = h + HASH_W'(b);
        c = a + (a << MIX_SHL);
        return c ^ (c >> MIX_SHR);
    endfunction

endpackage

// ===== rtl/ooat_fifo.sv =====
module ooat_fifo
    import ooat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [HASH_W-1:0] i_data,
    input  logic              i_pop,
    output logic [HASH_W-1:0] o_data,
    output t_fifo_stat        o_stat
);

    logic [HASH_W-1:0]  r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr   = i_push && !o_stat.full;
    assign w_rd   = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FIFO_CW'(FIFO_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/ooat_front.sv =====
module ooat_front
    import ooat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic              i_last,
    input  t_fifo_stat        i_q_stat,
    output logic              o_full,
    output logic              o_q_push,
    output logic [HASH_W-1:0] o_q_data
);

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic              w_accept;

    assign o_full   = i_q_stat.full;
    assign w_accept = i_push && !i_q_stat.full;
    assign o_q_data = mix_byte(r_hash, i_key_byte);
    assign o_q_push = w_accept && i_last;

    always_comb begin
        n_hash = r_hash;
        if (w_accept) begin
            n_hash = i_last ? '0 : o_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            r_hash <= n_hash;
        end
    end

    // a finished key leaves a clean hash behind
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_hash == '0))
        else $error("running hash not cleared after last word");

endmodule

// ===== rtl/ooat_back.sv =====
module ooat_back
    import ooat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  t_fifo_stat        i_q_stat,
    input  logic [HASH_W-1:0] i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [HASH_W-1:0] o_key_hash,
    output logic [SIZE_W-1:0] o_bucket_index
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [SIZE_W-1:0]    r_table_size;
    logic [HASH_W-1:0]    r_h;
    logic [HASH_W-1:0]    r_shift;
    logic [SIZE_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic                 w_out_load;
    logic                 w_div_last;
    logic [SIZE_W-1:0]    w_divisor;
    logic [SIZE_W:0]      w_trial;
    logic [SIZE_W-1:0]    w_rem_next;

    // zero buckets behaves as one bucket
    assign w_divisor  = (r_table_size == '0) ? SIZE_W'(1) : r_table_size;
    assign w_trial    = {r_rem, r_shift[HASH_W-1]};
    assign w_rem_next = (w_trial >= {1'b0, w_divisor}) ? SIZE_W'(w_trial - {1'b0, w_divisor})
                                                       : w_trial[SIZE_W-1:0];
    assign w_div_last = (r_cnt == DIV_CNT_W'(HASH_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: n_state = S_FIN2;
            S_FIN2: n_state = S_FIN3;
            S_FIN3: n_state = S_DIV;
            S_DIV: begin
                if (w_div_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_q_pop    = !i_q_stat.empty;
            S_HOLD:  w_out_load = !r_out_valid || i_pop;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= TABLE_SIZE_RST;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_h <= i_q_data;
            S_FIN1: r_h <= r_h + (r_h << FIN_SHL_A);
            S_FIN2: r_h <= r_h ^ (r_h >> FIN_SHR);
            S_FIN3: begin
                r_h     <= r_h + (r_h << FIN_SHL_B);
                r_shift <= r_h + (r_h << FIN_SHL_B);
                r_rem   <= '0;
            end
            S_DIV: begin
                r_rem   <= w_rem_next;
                r_shift <= r_shift << 1;
            end
            default: ;
        endcase
        if (w_out_load) begin
            o_key_hash     <= r_h;
            o_bucket_index <= r_rem;
        end
    end

    assign o_empty = !r_out_valid;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> (r_rem < w_divisor))
        else $error("remainder not reduced");

    a_cnt_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_cnt == '0))
        else $error("divide counter running outside divide");

endmodule

// ===== rtl/one_at_a_time_hash_bucket.sv =====
// channel   | handshake                  | data
// ----------+----------------------------+------------------------------
// input     | push / full                | i_key_byte, i_last
// result    | empty / pop                | o_key_hash, o_bucket_index
// config    | i_cfg_we                   | i_cfg_wdata (table size)
//
// key bytes are taken one per cycle while the 4-entry key queue has room
// each finished key passes through the back end: pop, 3 final-mix steps,
// 32 steps of the bit-serial remainder unit, then handoff to the result register
// reset clears the running hash, the queue and the result valid flag, table size goes to 1021
// a stalled result holds the back end, which then fills the queue and raises full
module one_at_a_time_hash_bucket
    import ooat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic              i_last,
    output logic              empty,
    input  logic              pop,
    output logic [HASH_W-1:0] o_key_hash,
    output logic [SIZE_W-1:0] o_bucket_index,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);

    t_fifo_stat        w_q_stat;
    logic              w_q_push;
    logic [HASH_W-1:0] w_q_wdata;
    logic              w_q_pop;
    logic [HASH_W-1:0] w_q_rdata;

    ooat_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_key_byte (i_key_byte),
        .i_last     (i_last),
        .i_q_stat   (w_q_stat),
        .o_full     (full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    ooat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    ooat_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_stat       (w_q_stat),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_key_hash     (o_key_hash),
        .o_bucket_index (o_bucket_index)
    );

endmodule
